/* hdl/assert_macros.svh */
// Assertion macros shared by the neighbor table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, off while reset is held.
`define NTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define NTA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NTA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/nta_pkg.sv */
// Types, codes and sizes shared by the neighbor table modules.
`timescale 1ns / 1ps
package nta_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int OUT_CNT_W   = 5;
  localparam int ID_W        = 32;
  localparam int ADDR_W      = 32;
  localparam int ALIVE_W     = 8;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_IFACE_ADDR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IFACE_MASK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALIVE_RELOAD = 2'd2;

  localparam logic [ALIVE_W-1:0] ALIVE_RELOAD_RST = 8'd40;

  localparam logic OPC_HELLO = 1'b0;
  localparam logic OPC_TICK  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_REFRESHED       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ADDED           = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MASK_MISMATCH   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SUBNET_MISMATCH = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL            = 3'd4;
  localparam logic [STATUS_W-1:0] ST_TICK            = 3'd5;

  // What the token asks of each cell it passes.
  typedef enum logic [1:0] {
    TOK_NONE    = 2'd0,
    TOK_REFRESH = 2'd1,
    TOK_ADD     = 2'd2,
    TOK_AGE     = 2'd3
  } tok_op_e;

  typedef struct packed {
    logic             valid;
    tok_op_e          op;
    logic             placed;
    logic [CNT_W-1:0] removed;
  } tok_t;

endpackage

/* hdl/nta_cell.sv */
// One table entry: holds a neighbor and acts on the token passing through.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nta_cell
  import nta_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tok_t               tok_i,
  input  logic [ID_W-1:0]    rid_i,
  input  logic [ALIVE_W-1:0] reload_i,
  output logic               match_o,
  output tok_t               tok_o
);

  logic               valid_q, valid_d;
  logic [ID_W-1:0]    id_q, id_d;
  logic [ALIVE_W-1:0] alive_q, alive_d;
  tok_t               tok_q, tok_d;

  assign match_o = valid_q && (id_q == rid_i);
  assign tok_o   = tok_q;

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    alive_d = alive_q;
    tok_d   = tok_i;
    if (tok_i.valid) begin
      case (tok_i.op)
        TOK_REFRESH: begin
          if (match_o) begin
            alive_d = reload_i;
          end
        end
        TOK_ADD: begin
          // The first free cell along the chain takes the new neighbor.
          if (!valid_q && !tok_i.placed) begin
            valid_d      = 1'b1;
            id_d         = rid_i;
            alive_d      = reload_i;
            tok_d.placed = 1'b1;
          end
        end
        TOK_AGE: begin
          if (valid_q) begin
            if (alive_q == '0) begin
              valid_d       = 1'b0;
              tok_d.removed = tok_i.removed + CNT_W'(1);
            end else begin
              alive_d = alive_q - ALIVE_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    alive_q <= alive_d;
  end

  `NTA_ASSERT_NXT(a_tok_from_left, !tok_i.valid, !tok_q.valid, "token appeared without input")
  `NTA_ASSERT_NXT(a_placed_kept, tok_i.valid && tok_i.placed, tok_q.placed,
                  "placed flag lost in cell")
  `NTA_ASSERT_NXT(a_add_once, tok_i.valid && tok_i.op == TOK_ADD && tok_i.placed,
                  $stable(valid_q), "entry taken after neighbor was placed")

endmodule

/* hdl/neighbor_table_aging.sv */
// Top level of the neighbor table with dead timer for one interface.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
// An item (a hello or a tick) is transferred at a rising clock edge where
// start_i is high and busy_o is low. busy_o then stays high until the
// result is ready. Each item yields one result, shown on the result ports
// for exactly one cycle while result_valid_o is high; the receiver cannot
// stall it, so it must take it in that cycle.
// An accepted item sets the launch register; a token then walks the row of
// TABLE_DEPTH cells, one cell per cycle, registered in each cell. The first
// hop also looks up the router id in every cell, and the result registers
// then form the result and raise the strobe. The result is transferred at
// the edge that ends the strobe cycle, and a new item can be transferred at
// that same edge, not before: the block takes no new item while a token is
// still in the cell row.
// Configuration writes use their own valid/ready channel; ready is always
// high and writes are expected only while the block is idle. Index 0 is the
// interface address, 1 the interface mask, 2 the alive reload value; other
// indexes are ignored.
// Reset clears every entry's valid bit at once, the neighbor count and the
// configuration registers (reload value 40); no clearing pass is needed.
module neighbor_table_aging
  import nta_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  opcode_i,
  input  logic [ID_W-1:0]       router_id_i,
  input  logic [ADDR_W-1:0]     source_addr_i,
  input  logic [ADDR_W-1:0]     hello_mask_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  result_valid_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic                  changed_o,
  output logic [OUT_CNT_W-1:0]  removed_count_o,
  output logic [OUT_CNT_W-1:0]  neighbor_count_o
);

  // Configuration registers.
  logic [ADDR_W-1:0]  iface_addr_q;
  logic [ADDR_W-1:0]  iface_mask_q;
  logic [ALIVE_W-1:0] alive_reload_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iface_addr_q   <= '0;
      iface_mask_q   <= '0;
      alive_reload_q <= ALIVE_RELOAD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_IFACE_ADDR:   iface_addr_q   <= cfg_data_i;
        REG_IFACE_MASK:   iface_mask_q   <= cfg_data_i;
        REG_ALIVE_RELOAD: alive_reload_q <= cfg_data_i[ALIVE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Command capture. The item fields are held for the whole walk so that
  // every cell can compare against the same router id.
  logic              accept;
  logic              busy_q;
  logic              launch_q;
  logic              opcode_q;
  logic [ID_W-1:0]   rid_q;
  logic [ADDR_W-1:0] src_q;
  logic [ADDR_W-1:0] hmask_q;

  assign accept = start_i && !busy_q;
  assign busy_o = busy_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      opcode_q <= opcode_i;
      rid_q    <= router_id_i;
      src_q    <= source_addr_i;
      hmask_q  <= hello_mask_i;
    end
  end

  // Cell row. Every cell compares its id in parallel during the launch
  // cycle; the token then carries the decision down the row.
  tok_t                   tok_chain [TABLE_DEPTH+1];
  tok_t                   tok_head;
  logic [TABLE_DEPTH-1:0] match;
  logic                   hit;
  logic                   mask_ok;
  logic                   subnet_ok;
  logic [STATUS_W-1:0]    pre_status;
  logic [STATUS_W-1:0]    pre_status_q;
  tok_t                   tok_last;

  assign hit       = |match;
  assign mask_ok   = (hmask_q == iface_mask_q);
  assign subnet_ok = ((iface_addr_q & iface_mask_q) == (src_q & hmask_q));

  always_comb begin
    tok_head         = '0;
    tok_head.valid   = launch_q;
    pre_status       = ST_TICK;
    if (opcode_q == OPC_TICK) begin
      tok_head.op = TOK_AGE;
    end else if (hit) begin
      // A known router id is refreshed whatever its mask and source.
      tok_head.op = TOK_REFRESH;
      pre_status  = ST_REFRESHED;
    end else if (!mask_ok) begin
      tok_head.op = TOK_NONE;
      pre_status  = ST_MASK_MISMATCH;
    end else if (!subnet_ok) begin
      tok_head.op = TOK_NONE;
      pre_status  = ST_SUBNET_MISMATCH;
    end else begin
      tok_head.op = TOK_ADD;
      pre_status  = ST_ADDED;
    end
  end

  assign tok_chain[0] = tok_head;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    nta_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .tok_i    (tok_chain[g]),
      .rid_i    (rid_q),
      .reload_i (alive_reload_q),
      .match_o  (match[g]),
      .tok_o    (tok_chain[g+1])
    );
  end

  assign tok_last = tok_chain[TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (launch_q) begin
      pre_status_q <= pre_status;
    end
  end

  // Sequencing and the neighbor count.
  logic [CNT_W-1:0] count_q, count_d;
  logic             result_valid_q;

  always_comb begin
    count_d = count_q;
    if (tok_last.op == TOK_ADD && tok_last.placed) begin
      count_d = count_q + CNT_W'(1);
    end else if (tok_last.op == TOK_AGE) begin
      count_d = (count_q >= tok_last.removed) ? count_q - tok_last.removed : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q         <= 1'b0;
      launch_q       <= 1'b0;
      result_valid_q <= 1'b0;
      count_q        <= '0;
    end else begin
      launch_q       <= accept;
      result_valid_q <= tok_last.valid;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (tok_last.valid) begin
        busy_q <= 1'b0;
      end
      if (tok_last.valid) begin
        count_q <= count_d;
      end
    end
  end

  // Result registers.
  logic [STATUS_W-1:0] status_q;
  logic                changed_q;
  logic [CNT_W-1:0]    removed_q;

  always_ff @(posedge clk_i) begin
    if (tok_last.valid) begin
      removed_q <= tok_last.removed;
      case (tok_last.op)
        TOK_AGE: begin
          status_q  <= ST_TICK;
          changed_q <= (tok_last.removed != '0);
        end
        TOK_ADD: begin
          status_q  <= tok_last.placed ? ST_ADDED : ST_FULL;
          changed_q <= tok_last.placed;
        end
        default: begin
          status_q  <= pre_status_q;
          changed_q <= 1'b0;
        end
      endcase
    end
  end

  assign result_valid_o   = result_valid_q;
  assign status_o         = status_q;
  assign changed_o        = changed_q;
  assign removed_count_o  = OUT_CNT_W'(removed_q);
  assign neighbor_count_o = OUT_CNT_W'(count_q);

  `NTA_ASSERT_IMP(a_strobe_idle, result_valid_q, !busy_q, "result shown while busy")
  `NTA_ASSERT_NXT(a_accept_launch, accept, launch_q && busy_q, "accepted item not launched")
  `NTA_ASSERT_IMP(a_token_busy, tok_last.valid, busy_q, "token left row while idle")
  `NTA_ASSERT(a_count_range, count_q <= CNT_W'(TABLE_DEPTH), "neighbor count above depth")
  `NTA_ASSERT_IMP(a_added_changed, result_valid_q && status_q == ST_ADDED, changed_q,
                  "add without changed flag")

endmodule

/* verif/neighbor_table_aging_test.sv */
// Self-checking testbench for the neighbor table with dead timer.
`timescale 1ns / 1ps
module neighbor_table_aging_test;
  import nta_pkg::*;

  // Index 3 has no register behind it; writes to it must leave the block unchanged.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Interval from the transfer of an item to the transfer of its result.
  localparam int RESULT_LATENCY = TABLE_DEPTH + 2;

  // Cycles without any transfer or result before the run is declared hung.
  // The slowest legal gap is one item latency plus a short run of sender idles.
  localparam int WATCHDOG_LIMIT = 2000;

  localparam int NUM_ROWS   = 19;
  localparam int NUM_PHASES = 6;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 changed;
    logic [OUT_CNT_W-1:0] removed;
    logic [OUT_CNT_W-1:0] count;
  } result_t;

  typedef struct packed {
    logic              op;
    logic [ID_W-1:0]   rid;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] hmask;
  } item_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // One row of the directed table: either a register write or an item that is
  // sent rep times with router id and source address counting up. Where chk is
  // set, the typed result is what the block must return.
  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  op;
    logic [ID_W-1:0]       rid;
    logic [ADDR_W-1:0]     src;
    logic [ADDR_W-1:0]     hmask;
    int                    rep;
    logic                  chk;
    logic [STATUS_W-1:0]   st;
    logic                  ch;
    logic [OUT_CNT_W-1:0]  rm;
    logic [OUT_CNT_W-1:0]  cnt;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic                  opcode_i = OPC_HELLO;
  logic [ID_W-1:0]       router_id_i = '0;
  logic [ADDR_W-1:0]     source_addr_i = '0;
  logic [ADDR_W-1:0]     hello_mask_i = '0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = REG_IFACE_ADDR;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  result_valid_o;
  logic [STATUS_W-1:0]   status_o;
  logic                  changed_o;
  logic [OUT_CNT_W-1:0]  removed_count_o;
  logic [OUT_CNT_W-1:0]  neighbor_count_o;

  neighbor_table_aging i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .opcode_i         (opcode_i),
    .router_id_i      (router_id_i),
    .source_addr_i    (source_addr_i),
    .hello_mask_i     (hello_mask_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .changed_o        (changed_o),
    .removed_count_o  (removed_count_o),
    .neighbor_count_o (neighbor_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Our own copy of the neighbor table and of the interface settings. The
  // settings change only on a write transfer seen at the configuration port.
  logic                  nbr_valid [TABLE_DEPTH] = '{default: 1'b0};
  logic [ID_W-1:0]       nbr_id    [TABLE_DEPTH] = '{default: '0};
  logic [ALIVE_W-1:0]    nbr_alive [TABLE_DEPTH] = '{default: '0};
  int                    nbr_count = 0;
  logic [ADDR_W-1:0]     cfg_addr = '0;
  logic [ADDR_W-1:0]     cfg_mask = '0;
  logic [ALIVE_W-1:0]    cfg_reload = ALIVE_RELOAD_RST;

  // Results still owed by the block, oldest first.
  result_t pending_results[$];

  // The main process sets these before each directed item; the monitor reads
  // them at the transfer edge.
  bit      use_typed = 1'b0;
  result_t typed_result = '0;

  // Random idles of the sender are switched off for one whole phase.
  bit      idling_on = 1'b1;

  int      mismatch_count = 0;
  int      quiet_cycles = 0;

  // Applies one hello or tick to the table copy and returns what it yields.
  // A known router id is refreshed before any check of mask or subnet. A new
  // id is then checked for mask, subnet and free room, in that order.
  function automatic result_t table_update(input logic op, input logic [ID_W-1:0] rid,
                                           input logic [ADDR_W-1:0] src,
                                           input logic [ADDR_W-1:0] hmask);
    result_t res;
    int      hit;
    int      free_slot;
    int      gone;
    res       = '0;
    hit       = -1;
    free_slot = -1;
    gone      = 0;
    if (op == OPC_TICK) begin
      // An entry whose counter has already reached zero dies on this tick.
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (nbr_valid[i]) begin
          if (nbr_alive[i] == '0) begin
            nbr_valid[i] = 1'b0;
            gone++;
          end else begin
            nbr_alive[i] = nbr_alive[i] - 1'b1;
          end
        end
      end
      nbr_count   = (nbr_count >= gone) ? nbr_count - gone : 0;
      res.status  = ST_TICK;
      res.changed = (gone != 0);
      res.removed = gone[OUT_CNT_W-1:0];
    end else begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (hit < 0 && nbr_valid[i] && nbr_id[i] == rid) hit = i;
        if (free_slot < 0 && !nbr_valid[i]) free_slot = i;
      end
      if (hit >= 0) begin
        nbr_alive[hit] = cfg_reload;
        res.status     = ST_REFRESHED;
      end else if (hmask != cfg_mask) begin
        res.status = ST_MASK_MISMATCH;
      end else if ((cfg_addr & cfg_mask) != (src & hmask)) begin
        res.status = ST_SUBNET_MISMATCH;
      end else if (free_slot < 0) begin
        res.status = ST_FULL;
      end else begin
        nbr_valid[free_slot] = 1'b1;
        nbr_id[free_slot]    = rid;
        nbr_alive[free_slot] = cfg_reload;
        nbr_count++;
        res.status  = ST_ADDED;
        res.changed = 1'b1;
      end
    end
    res.count = nbr_count[OUT_CNT_W-1:0];
    return res;
  endfunction

  // Everything is sampled at the rising edge, in one process: first the result
  // of this edge is checked, then a configuration transfer and an item transfer
  // of the same edge update the table copy. The watchdog counts edges at which
  // none of these happened.
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    bit      progress;
    progress = 1'b0;
    if (rst_ni) begin
      if (result_valid_o) begin
        progress = 1'b1;
        got      = '{status_o, changed_o, removed_count_o, neighbor_count_o};
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result %0d/%0d/%0d/%0d arrived with nothing pending", $time,
                     got.status, got.changed, got.removed, got.count);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.changed !== want.changed ||
              got.removed !== want.removed || got.count !== want.count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"%0t: status/changed/removed/count expected %0d/%0d/%0d/%0d,",
                        " got %0d/%0d/%0d/%0d"},
                       $time, want.status, want.changed, want.removed, want.count,
                       got.status, got.changed, got.removed, got.count);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        progress = 1'b1;
        case (cfg_index_i)
          REG_IFACE_ADDR:   cfg_addr = cfg_data_i;
          REG_IFACE_MASK:   cfg_mask = cfg_data_i;
          REG_ALIVE_RELOAD: cfg_reload = cfg_data_i[ALIVE_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        progress = 1'b1;
        want     = table_update(opcode_i, router_id_i, source_addr_i, hello_mask_i);
        pending_results.push_back(use_typed ? typed_result : want);
      end
      quiet_cycles = progress ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offers one item from the falling edge on until it is transferred. In each
  // cycle the sender may idle instead, so idles also fall while the block is
  // busy and in the cycle in which it becomes free.
  task automatic send_item(input item_t it);
    bit taken;
    taken = 1'b0;
    while (!taken) begin
      if (idling_on && $urandom_range(0, 99) < 14) begin
        start_i <= 1'b0;
      end else begin
        start_i       <= 1'b1;
        opcode_i      <= it.op;
        router_id_i   <= it.rid;
        source_addr_i <= it.src;
        hello_mask_i  <= it.hmask;
      end
      @(posedge clk_i);
      taken = start_i && !busy_o;
      @(negedge clk_i);
    end
  endtask

  // Holds off the sender until every owed result has come back.
  task automatic drain();
    while (pending_results.size() != 0) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  // One register write; a cycle with valid low follows so that back-to-back
  // writes never assign the valid twice in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    bit done;
    done = 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    while (!done) begin
      @(posedge clk_i);
      done = cfg_ready_o;
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    row_t              directed_rows [NUM_ROWS];
    item_t             it;
    logic [ADDR_W-1:0] ph_addr   [NUM_PHASES];
    logic [ADDR_W-1:0] ph_mask   [NUM_PHASES];
    logic [ALIVE_W-1:0] ph_reload [NUM_PHASES];
    int                ph_items  [NUM_PHASES];
    logic [ADDR_W-1:0] well_src;
    logic [ID_W-1:0]   id_base;
    int                plen;
    int                pick;

    // The first rows run with the reset settings: address 0, mask 0, reload 40.
    // Under those, a hello with mask 0 always matches the subnet. Later rows
    // move to 192.168.0.1/24 and a reload of 0, then fill the table to the top.
    directed_rows = '{
      // A tick on the empty table removes nothing.
      '{ROW_ITEM, REG_IFACE_ADDR, 32'h0, OPC_TICK, 32'h0, 32'h0, 32'h0, 1,
        1'b1, ST_TICK, 1'b0, 5'd0, 5'd0},
      // Lowest and highest router ids and addresses are both added.
      '{ROW_ITEM, REG_IFACE_ADDR, 32'h0, OPC_HELLO, 32'h0, 32'h0, 32'h0, 1,
        1'b1, ST_ADDED, 1'b1, 5'd0, 5'd1},
      '{ROW_ITEM, REG_IFACE_ADDR, 32'h0, OPC_HELLO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1,
        1'b1, ST_ADDED, 1'b1, 5'd0, 5'd2},
      // A known id is refreshed even though its mask is wrong.
      '{ROW_ITEM, REG_IFACE_ADDR, 32'h0, OPC_HELLO, 32'hFFFF_FFFF, 32'h1234_5678,
        32'hFFFF_FFFF, 1, 1'b1, ST_REFRESHED, 1'b0, 5'd0, 5'd2},
      '{ROW_ITEM, REG_IFACE_ADDR, 32'h0, OPC_HELLO, 32'h7, 32'h0, 32'hFFFF_FFFF, 1,
        1'b1, ST_MASK_MISMATCH, 1'b0, 5'd0, 5'd2},
      '{ROW_CFG, REG_IFACE_ADDR, 32'hC0A8_0001, OPC_HELLO, 32'h0, 32'h0, 32'h0, 0,
        1'b0, ST_REFRESHED, 1'b0, 5'd0, 5'd0},
      '{ROW_CFG, REG_IFACE_MASK, 32'hFFFF_FF00, OPC_HELLO, 32'h0, 32'h0, 32'h0, 0,
        1'b0, ST_REFRESHED, 1'b0, 5'd0, 5'd0},
      '{ROW_CFG, REG_ALIVE_RELOAD, 32'h0, OPC_HELLO, 32'h0, 32'h0, 32'h0, 0,
        1'b0, ST_REFRESHED, 1'b0, 5'd0, 5'd0},
      // A write to the unused index must change nothing.
      '{ROW_CFG, REG_UNUSED, 32'hFFFF_FFFF, OPC_HELLO, 32'h0, 32'h0, 32'h0, 0,
        1'b0, ST_REFRESHED, 1'b0, 5'd0, 5'd0},
      '{ROW_ITEM, REG_IFACE_ADDR, 32'h0, OPC_HELLO, 32'h8, 32'hC0A8_0105, 32'hFFFF_FF00, 1,
        1'b1, ST_SUBNET_MISMATCH, 1'b0, 5'd0, 5'd2},
      // Wrong mask and wrong subnet together: the mask is reported.
      '{ROW_ITEM, REG_IFACE_ADDR, 32'h0, OPC_HELLO, 32'h8, 32'hC0A8_0105, 32'hFFFF_FFFE, 1,
        1'b1, ST_MASK_MISMATCH, 1'b0, 5'd0, 5'd2},
      // Added with a reload of zero, so the next tick removes it.
      '{ROW_ITEM, REG_IFACE_ADDR, 32'h0, OPC_HELLO, 32'h9, 32'hC0A8_0042, 32'hFFFF_FF00, 1,
        1'b1, ST_ADDED, 1'b1, 5'd0, 5'd3},
      // A tick ignores whatever stands on the hello fields.
      '{ROW_ITEM, REG_IFACE_ADDR, 32'h0, OPC_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 1, 1'b1, ST_TICK, 1'b1, 5'd1, 5'd2},
      '{ROW_CFG, REG_ALIVE_RELOAD, 32'hFF, OPC_HELLO, 32'h0, 32'h0, 32'h0, 0,
        1'b0, ST_REFRESHED, 1'b0, 5'd0, 5'd0},
      // Fourteen new neighbors fill the table.
      '{ROW_ITEM, REG_IFACE_ADDR, 32'h0, OPC_HELLO, 32'h100, 32'hC0A8_0010, 32'hFFFF_FF00, 14,
        1'b0, ST_ADDED, 1'b0, 5'd0, 5'd0},
      // On a full table the subnet check still comes before the room check.
      '{ROW_ITEM, REG_IFACE_ADDR, 32'h0, OPC_HELLO, 32'hAAAA, 32'hC0A8_0133, 32'hFFFF_FF00, 1,
        1'b1, ST_SUBNET_MISMATCH, 1'b0, 5'd0, 5'd16},
      '{ROW_ITEM, REG_IFACE_ADDR, 32'h0, OPC_HELLO, 32'hAAAA, 32'hC0A8_00FF, 32'hFFFF_FF00, 1,
        1'b1, ST_FULL, 1'b0, 5'd0, 5'd16},
      '{ROW_ITEM, REG_IFACE_ADDR, 32'h0, OPC_HELLO, 32'h0, 32'h0, 32'hFFFF_FFFF, 1,
        1'b1, ST_REFRESHED, 1'b0, 5'd0, 5'd16},
      '{ROW_ITEM, REG_IFACE_ADDR, 32'h0, OPC_TICK, 32'h0, 32'h0, 32'h0, 1,
        1'b0, ST_TICK, 1'b0, 5'd0, 5'd0}
    };

    // Settings of the random phases. The first four are fixed and cover the
    // extremes of the reload (1, 255 and 0) and of the mask (all ones, zero);
    // the last two draw address and mask at random, the first of them also the reload.
    ph_addr   = '{32'hC0A8_0001, 32'h0A00_00FE, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0};
    ph_mask   = '{32'hFFFF_FF00, 32'hFF00_0000, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0};
    ph_reload = '{8'd2, 8'd1, 8'd255, 8'd0, 8'd1, 8'd3};
    ph_items  = '{150, 120, 80, 100, 150, 150};
    plen         = $urandom_range(0, 32);
    ph_addr[4]   = $urandom;
    ph_mask[4]   = (plen == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - plen));
    ph_reload[4] = ALIVE_W'($urandom_range(1, 6));
    ph_addr[5]   = $urandom;
    ph_mask[5]   = $urandom;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_CFG) begin
        drain();
        write_reg(directed_rows[k].idx, directed_rows[k].data);
      end else begin
        for (int j = 0; j < directed_rows[k].rep; j++) begin
          it = '{directed_rows[k].op, directed_rows[k].rid + j, directed_rows[k].src + j,
                 directed_rows[k].hmask};
          use_typed    = directed_rows[k].chk;
          typed_result = '{directed_rows[k].st, directed_rows[k].ch, directed_rows[k].rm,
                           directed_rows[k].cnt};
          send_item(it);
        end
      end
    end
    use_typed = 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      write_reg(REG_IFACE_ADDR, ph_addr[ph]);
      write_reg(REG_IFACE_MASK, ph_mask[ph]);
      write_reg(REG_ALIVE_RELOAD, {24'h0, ph_reload[ph]});
      write_reg(REG_UNUSED, $urandom);
      // The second phase runs with no sender idles at all.
      idling_on = (ph != 1);
      // Router ids come mostly from a pool of 24, so the table both fills up
      // and sees plenty of refreshes.
      id_base = $urandom;
      for (int n = 0; n < ph_items[ph]; n++) begin
        // Now and then the sender waits for the block to run dry.
        if ($urandom_range(0, 99) < 2) drain();
        pick     = $urandom_range(0, 99);
        well_src = (ph_addr[ph] & ph_mask[ph]) | ($urandom & ~ph_mask[ph]);
        it       = '{OPC_HELLO, id_base + $urandom_range(0, 23), well_src, ph_mask[ph]};
        if (pick < 18) begin
          it = '{OPC_TICK, $urandom, $urandom, $urandom};
        end else if (pick < 78) begin
          // Well-formed hello, as set up above.
        end else if (pick < 85) begin
          it.hmask = ph_mask[ph] ^ (32'h1 << $urandom_range(0, 31));
          it.src   = $urandom;
        end else if (pick < 92) begin
          it.src = well_src ^ (ph_mask[ph] & $urandom);
        end else begin
          it = '{OPC_HELLO, $urandom, $urandom, $urandom};
        end
        send_item(it);
      end
    end

    drain();
    // Any stray result would show up within one more item latency.
    repeat (RESULT_LATENCY + 4) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* neighbor_table_aging.f */
+incdir+hdl
hdl/nta_pkg.sv
hdl/nta_cell.sv
hdl/neighbor_table_aging.sv
verif/neighbor_table_aging_test.sv
